// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the frame checker RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising edge outside of reset.
`define ASSERT_CHK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Condition must never be true outside of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  `ASSERT_CHK(lbl, clk, rstn, !(cond))
`else
`define ASSERT_CHK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== hdl/mlcfc_pkg.sv =====
// ---------------------------------------------------------------------------
// mlcfc_pkg
// Types, constants and the CRC-32C byte update for the frame checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mlcfc_pkg;

  // Number of magic header bytes that are compared (1 to 12).
  localparam int MagicBytes = 12;
  localparam int MagicIdxW  = (MagicBytes > 1) ? $clog2(MagicBytes) : 1;

  // Header, length and CRC bytes that surround the body.
  localparam logic [16:0] FrameOverhead = 17'(MagicBytes + 2 + 4);

  localparam logic [15:0] MaxBodyLenReset = 16'd1000;
  localparam logic [31:0] Crc32cPoly      = 32'h82F6_3B78;
  localparam logic [31:0] CrcInit         = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CFG_MAGIC_HIGH   = 2'd0,
    CFG_MAGIC_LOW    = 2'd1,
    CFG_MAX_BODY_LEN = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_MAGIC = 2'd0,
    PH_LEN   = 2'd1,
    PH_BODY  = 2'd2,
    PH_CRC   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MAGIC    = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_CRC      = 2'd3
  } status_e;

  // Reflected CRC-32C update with one byte, one bit per step.
  function automatic logic [31:0] crc32c_byte(logic [31:0] crc, logic [7:0] data);
    logic [31:0] c;
    c = crc ^ {24'h0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ Crc32cPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/magic_length_crc_frame_checker.sv =====
// ---------------------------------------------------------------------------
// magic_length_crc_frame_checker
// Checks length-prefixed frames with a magic header and a CRC-32C trailer.
// ---------------------------------------------------------------------------
// The input channel carries one stream byte per word (in_valid_i, in_stall_o,
// stream_byte_i). A frame is a 12-byte magic header, a big-endian 16-bit body
// length, the body and a big-endian CRC-32C over everything before it.
// The output channel (out_valid_o, out_stall_i) carries at most one word per
// input byte: either a forwarded body byte, or a status word that closes a
// frame (ok with the total frame length, or CRC mismatch) or reports a magic
// or length error at once, after which the checker hunts for a new header.
// Matching header bytes, length bytes within the limit and the first three CRC bytes produce no word.
// A result word is registered in the output register when its byte is
// accepted. Throughput: one byte per cycle unless the input is stalled, set
// by the combinational CRC byte update and phase logic feeding the output register.
// When the receiver stalls, the output register holds its word and the input
// is stalled only while that register is full and not being drained.
// Configuration (cfg_we_i, cfg_index_i, cfg_wdata_i) writes the magic words
// and the body length limit; the user must write it only while the block is idle,
// which the block does not enforce. Reset clears the magic words, sets the
// length limit to 1000 and starts a header search with a fresh CRC.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module magic_length_crc_frame_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [63:0] cfg_wdata_i,
  // Input byte channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  stream_byte_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       body_byte_o,
  output logic             body_valid_o,
  output logic             status_valid_o,
  output logic [1:0]       frame_status_o,
  output logic [16:0]      frame_length_o
);
  import mlcfc_pkg::*;

  // Configuration registers.
  logic [31:0] magic_high_q;
  logic [63:0] magic_low_q;
  logic [15:0] max_body_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_high_q   <= '0;
      magic_low_q    <= '0;
      max_body_len_q <= MaxBodyLenReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAGIC_HIGH:   magic_high_q   <= cfg_wdata_i[31:0];
        CFG_MAGIC_LOW:    magic_low_q    <= cfg_wdata_i;
        CFG_MAX_BODY_LEN: max_body_len_q <= cfg_wdata_i[15:0];
        default: begin
          // Writes to undefined indexes are ignored.
        end
      endcase
    end
  end

  // Expected magic bytes, the first one in the top byte of magic_high.
  logic [95:0] magic_all;
  logic [7:0]  magic_bytes [MagicBytes];

  assign magic_all = {magic_high_q, magic_low_q};

  for (genvar g = 0; g < MagicBytes; g++) begin : g_magic
    assign magic_bytes[g] = magic_all[95 - 8*g -: 8];
  end

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [15:0] idx_q, idx_d;
  logic [15:0] body_len_q, body_len_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] crc_rx_q, crc_rx_d;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [7:0]  body_byte_q;
  logic        body_valid_q;
  logic        status_valid_q;
  status_e     frame_status_q;
  logic [16:0] frame_length_q;

  logic        in_fire;
  logic [31:0] crc_upd;
  logic [16:0] idx_inc;
  logic [31:0] crc_rx_shift;
  logic        magic_hit;
  logic        len_too_long;
  logic        crc_last;

  // Result of the current byte.
  logic        res_valid;
  logic        res_body;
  logic        res_status;
  status_e     res_code;
  logic [16:0] res_length;

  // The output register can take a word whenever it is empty or drained now.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_fire    = in_valid_i && !in_stall_o;

  assign crc_upd      = crc32c_byte(crc_q, stream_byte_i);
  assign idx_inc      = {1'b0, idx_q} + 17'd1;
  assign crc_rx_shift = {crc_rx_q[23:0], stream_byte_i};
  assign magic_hit    = stream_byte_i == magic_bytes[idx_q[MagicIdxW-1:0]];
  assign len_too_long = {body_len_q[7:0], stream_byte_i} > max_body_len_q;
  assign crc_last     = idx_q[1:0] == 2'd3;

  // Next-state logic.
  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    body_len_d = body_len_q;
    crc_d      = crc_q;
    crc_rx_d   = crc_rx_q;
    case (phase_q)
      PH_MAGIC: begin
        if (!magic_hit) begin
          idx_d = '0;
          crc_d = CrcInit;
        end else begin
          crc_d = crc_upd;
          if (idx_q == 16'(MagicBytes - 1)) begin
            phase_d = PH_LEN;
            idx_d   = '0;
          end else begin
            idx_d = idx_inc[15:0];
          end
        end
      end
      PH_LEN: begin
        crc_d      = crc_upd;
        body_len_d = {body_len_q[7:0], stream_byte_i};
        if (!idx_q[0]) begin
          idx_d = 16'd1;
        end else begin
          idx_d = '0;
          if (len_too_long) begin
            phase_d    = PH_MAGIC;
            body_len_d = '0;
            crc_d      = CrcInit;
          end else if (body_len_d == '0) begin
            phase_d = PH_CRC;
          end else begin
            phase_d = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        crc_d = crc_upd;
        if (idx_inc >= {1'b0, body_len_q}) begin
          phase_d = PH_CRC;
          idx_d   = '0;
        end else begin
          idx_d = idx_inc[15:0];
        end
      end
      PH_CRC: begin
        crc_rx_d = crc_rx_shift;
        if (crc_last) begin
          // Frame done either way: start hunting for the next header.
          phase_d    = PH_MAGIC;
          idx_d      = '0;
          body_len_d = '0;
          crc_d      = CrcInit;
          crc_rx_d   = '0;
        end else begin
          idx_d = idx_inc[15:0];
        end
      end
      default: begin
        phase_d    = PH_MAGIC;
        idx_d      = '0;
        body_len_d = '0;
        crc_d      = CrcInit;
        crc_rx_d   = '0;
      end
    endcase
  end

  // Result word logic.
  always_comb begin
    res_valid  = 1'b0;
    res_body   = 1'b0;
    res_status = 1'b0;
    res_code   = ST_OK;
    res_length = '0;
    case (phase_q)
      PH_MAGIC: begin
        if (!magic_hit) begin
          res_valid  = 1'b1;
          res_status = 1'b1;
          res_code   = ST_MAGIC;
        end
      end
      PH_LEN: begin
        if (idx_q[0] && len_too_long) begin
          res_valid  = 1'b1;
          res_status = 1'b1;
          res_code   = ST_TOO_LONG;
        end
      end
      PH_BODY: begin
        res_valid = 1'b1;
        res_body  = 1'b1;
      end
      PH_CRC: begin
        if (crc_last) begin
          res_valid  = 1'b1;
          res_status = 1'b1;
          if (crc_rx_shift == ~crc_q) begin
            res_code   = ST_OK;
            res_length = {1'b0, body_len_q} + FrameOverhead;
          end else begin
            res_code = ST_CRC;
          end
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = res_valid;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MAGIC;
      idx_q       <= '0;
      body_len_q  <= '0;
      crc_q       <= CrcInit;
      crc_rx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        phase_q    <= phase_d;
        idx_q      <= idx_d;
        body_len_q <= body_len_d;
        crc_q      <= crc_d;
        crc_rx_q   <= crc_rx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      body_byte_q    <= res_body ? stream_byte_i : 8'h00;
      body_valid_q   <= res_body;
      status_valid_q <= res_status;
      frame_status_q <= res_code;
      frame_length_q <= res_length;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign body_byte_o    = body_byte_q;
  assign body_valid_o   = body_valid_q;
  assign status_valid_o = status_valid_q;
  assign frame_status_o = frame_status_q;
  assign frame_length_o = frame_length_q;

  // A valid word is either a body byte or a status, never both or neither.
  `ASSERT_CHK(a_one_kind, clk_i, rst_ni,
              out_valid_q |-> $onehot({body_valid_q, status_valid_q}))
  // Only an ok status carries a frame length.
  `ASSERT_NEVER(a_len_only_ok, clk_i, rst_ni,
                out_valid_q && status_valid_q && frame_status_q != ST_OK &&
                frame_length_q != '0)
  // The body position stays below the announced length.
  `ASSERT_CHK(a_body_idx, clk_i, rst_ni,
              phase_q == PH_BODY |-> idx_q < body_len_q)
  // Every status word sends the parser back to a fresh header search.
  `ASSERT_CHK(a_status_hunts, clk_i, rst_ni,
              (in_fire && res_status) |=> (phase_q == PH_MAGIC && crc_q == CrcInit))

endmodule

`default_nettype wire

// ===== bench/frame_check_tb_pkg.sv =====
// ---------------------------------------------------------------------------
// Frame checker scoreboard
// Tracks the frame checker's state and queues the word expected for each byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package frame_check_tb_pkg;

  import mlcfc_pkg::*;

  typedef struct packed {
    logic [7:0]  body_byte;
    logic        body_valid;
    logic        status_valid;
    status_e     frame_status;
    logic [16:0] frame_length;
  } frame_result_t;

  class frame_scoreboard;
    logic [31:0]   magic_high;
    logic [63:0]   magic_low;
    logic [15:0]   max_body_len;
    phase_e        phase;
    logic [15:0]   pos;
    logic [15:0]   len_field;
    logic [31:0]   crc_acc;
    logic [31:0]   crc_seen;
    frame_result_t expected_q[$];
    int unsigned   mismatches;

    function new();
      magic_high   = '0;
      magic_low    = '0;
      max_body_len = MaxBodyLenReset;
      mismatches   = 0;
      restart();
    endfunction

    function void restart();
      phase     = PH_MAGIC;
      pos       = '0;
      len_field = '0;
      crc_acc   = CrcInit;
      crc_seen  = '0;
    endfunction

    // Writes to the unused index leave every register alone.
    function void write_reg(logic [1:0] idx, logic [63:0] data);
      case (idx)
        CFG_MAGIC_HIGH:   magic_high = data[31:0];
        CFG_MAGIC_LOW:    magic_low = data;
        CFG_MAX_BODY_LEN: max_body_len = data[15:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] magic_byte(int unsigned i);
      logic [95:0] hdr;
      hdr = {magic_high, magic_low};
      return hdr[95 - 8 * i -: 8];
    endfunction

    // Bit-serial reflected CRC-32C, data bits taken LSB first.
    function logic [31:0] crc_next(logic [31:0] c, logic [7:0] d);
      logic fb;
      for (int k = 0; k < 8; k++) begin
        fb = c[0] ^ d[k];
        c  = {1'b0, c[31:1]} ^ (fb ? Crc32cPoly : 32'h0);
      end
      return c;
    endfunction

    function void note_byte(logic [7:0] b);
      frame_result_t res;
      bit            emit;
      res  = '0;
      emit = 1'b0;
      case (phase)
        PH_MAGIC: begin
          if (b != magic_byte(pos)) begin
            restart();
            res.status_valid = 1'b1;
            res.frame_status = ST_MAGIC;
            emit = 1'b1;
          end else begin
            crc_acc = crc_next(crc_acc, b);
            pos     = pos + 16'd1;
            if (pos >= MagicBytes) begin
              phase = PH_LEN;
              pos   = '0;
            end
          end
        end
        PH_LEN: begin
          crc_acc   = crc_next(crc_acc, b);
          len_field = {len_field[7:0], b};
          if (pos == 16'd0) begin
            pos = 16'd1;
          end else begin
            pos = '0;
            if (len_field > max_body_len) begin
              restart();
              res.status_valid = 1'b1;
              res.frame_status = ST_TOO_LONG;
              emit = 1'b1;
            end else begin
              phase = (len_field == 16'd0) ? PH_CRC : PH_BODY;
            end
          end
        end
        PH_BODY: begin
          crc_acc = crc_next(crc_acc, b);
          pos     = pos + 16'd1;
          if (pos >= len_field) begin
            phase = PH_CRC;
            pos   = '0;
          end
          res.body_byte  = b;
          res.body_valid = 1'b1;
          emit = 1'b1;
        end
        PH_CRC: begin
          crc_seen = {crc_seen[23:0], b};
          pos      = pos + 16'd1;
          if (pos == 16'd4) begin
            res.status_valid = 1'b1;
            if (crc_seen == ~crc_acc) begin
              res.frame_status = ST_OK;
              res.frame_length = 17'(MagicBytes + 6) + 17'(len_field);
            end else begin
              res.frame_status = ST_CRC;
            end
            restart();
            emit = 1'b1;
          end
        end
        default: restart();
      endcase
      if (emit) expected_q.push_back(res);
    endfunction

    // Output is capped so that a badly broken design cannot flood the log.
    task report(string msg);
      if (mismatches < 100) $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("word with nothing expected: %p", got));
      end else begin
        want = expected_q.pop_front();
        if (got.body_byte !== want.body_byte)
          report($sformatf("body_byte %0h, expected %0h", got.body_byte, want.body_byte));
        if (got.body_valid !== want.body_valid)
          report($sformatf("body_valid %0b, expected %0b", got.body_valid, want.body_valid));
        if (got.status_valid !== want.status_valid)
          report($sformatf("status_valid %0b, expected %0b",
                           got.status_valid, want.status_valid));
        if (got.frame_status !== want.frame_status)
          report($sformatf("frame_status %0d, expected %0d",
                           got.frame_status, want.frame_status));
        if (got.frame_length !== want.frame_length)
          report($sformatf("frame_length %0d, expected %0d",
                           got.frame_length, want.frame_length));
      end
    endtask

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ===== bench/magic_length_crc_frame_checker_tb.sv =====
// ---------------------------------------------------------------------------
// magic_length_crc_frame_checker_tb
// Self-checking bench that streams framed bytes and checks every output word.
// ---------------------------------------------------------------------------
// The bench feeds whole frames (good, bad CRC, over-long, broken header) and
// loose noise bytes into the checker, under six register settings that range
// from all-zero and all-one magic words to the smallest and largest length
// limits. A scoreboard follows the checker's state for each accepted byte and
// compares every output word, field by field, with the oldest expected word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module magic_length_crc_frame_checker_tb;

  import mlcfc_pkg::*;
  import frame_check_tb_pkg::*;

  // Index 3 is not a register; writes to it must be ignored.
  localparam logic [1:0] CfgUnused = 2'd3;

  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned PhaseCount    = 6;
  localparam int unsigned ItemsPerPhase = 160;

  typedef enum {FR_GOOD, FR_BAD_CRC, FR_TOO_LONG, FR_BAD_MAGIC, FR_NOISE} frame_kind_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_index_i   = '0;
  logic [63:0] cfg_wdata_i   = '0;
  logic        in_valid_i    = 1'b0;
  logic [7:0]  stream_byte_i = '0;
  logic        out_stall_i   = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  body_byte_o;
  logic        body_valid_o;
  logic        status_valid_o;
  logic [1:0]  frame_status_o;
  logic [16:0] frame_length_o;

  frame_scoreboard sb = new();

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  // When set, neither side idles; this gives back-to-back stretches.
  bit          calm           = 1'b0;
  int unsigned bytes_sent     = 0;
  int unsigned quiet_cycles   = 0;

  magic_length_crc_frame_checker u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .stream_byte_i  (stream_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .body_byte_o    (body_byte_o),
    .body_valid_o   (body_valid_o),
    .status_valid_o (status_valid_o),
    .frame_status_o (frame_status_o),
    .frame_length_o (frame_length_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // The receiver stalls at random; the decision never looks at out_valid_o.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Both handshakes are sampled here, in one process, so that a byte is
  // always noted before any word it causes is checked. The watchdog counts
  // cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    frame_result_t got;
    bit            moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        sb.note_byte(stream_byte_i);
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        got.body_byte    = body_byte_o;
        got.body_valid   = body_valid_o;
        got.status_valid = status_valid_o;
        got.frame_status = status_e'(frame_status_o);
        got.frame_length = frame_length_o;
        sb.check_result(got);
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no word moved for %0d cycles", QuietLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Offers one byte and holds it until it is taken. When no idle cycle is
  // drawn, valid simply stays high with the next byte.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && ($urandom_range(0, 99) < send_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Builds one frame from the current magic words. A broken header keeps a
  // correct prefix and then one wrong byte; an over-long frame stops after
  // its length field, since the checker starts hunting right there.
  task automatic send_frame(input frame_kind_e kind, input logic [15:0] blen);
    logic [7:0]  bytes[$];
    logic [31:0] crc;
    int unsigned cut;
    crc = CrcInit;
    if (kind == FR_NOISE) begin
      repeat ($urandom_range(1, 4)) bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind == FR_BAD_MAGIC) begin
      cut = $urandom_range(0, MagicBytes - 1);
      for (int i = 0; i < cut; i++) bytes.push_back(sb.magic_byte(i));
      bytes.push_back(sb.magic_byte(cut) ^ 8'($urandom_range(1, 255)));
    end else begin
      for (int i = 0; i < MagicBytes; i++) bytes.push_back(sb.magic_byte(i));
      bytes.push_back(blen[15:8]);
      bytes.push_back(blen[7:0]);
      if (kind != FR_TOO_LONG) begin
        repeat (blen) bytes.push_back(8'($urandom_range(0, 255)));
        foreach (bytes[i]) crc = sb.crc_next(crc, bytes[i]);
        crc = ~crc;
        if (kind == FR_BAD_CRC) crc ^= 32'h1 << $urandom_range(0, 31);
        bytes.push_back(crc[31:24]);
        bytes.push_back(crc[23:16]);
        bytes.push_back(crc[15:8]);
        bytes.push_back(crc[7:0]);
      end
    end
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  // Mostly well-formed frames with short bodies; the rest are damaged frames
  // and noise. Over-long lengths hit the limit plus one and the top value too.
  task automatic send_random_frame();
    int unsigned pick;
    int unsigned cap;
    int unsigned lo;
    frame_kind_e kind;
    logic [15:0] blen;
    pick = $urandom_range(0, 99);
    if (pick < 60) kind = FR_GOOD;
    else if (pick < 72) kind = FR_BAD_CRC;
    else if (pick < 82) kind = FR_TOO_LONG;
    else if (pick < 92) kind = FR_BAD_MAGIC;
    else kind = FR_NOISE;
    if (kind == FR_TOO_LONG && sb.max_body_len == 16'hFFFF) kind = FR_BAD_CRC;
    cap = ($urandom_range(0, 9) == 0) ? 64 : 16;
    if (cap > sb.max_body_len) cap = sb.max_body_len;
    blen = 16'($urandom_range(0, cap));
    if (kind == FR_TOO_LONG) begin
      lo   = sb.max_body_len;
      lo   = lo + 1;
      pick = $urandom_range(0, 3);
      if (pick == 0) blen = 16'(lo);
      else if (pick == 1) blen = 16'hFFFF;
      else blen = 16'($urandom_range(lo, 65535));
    end
    calm = ($urandom_range(0, 7) == 0);
    send_frame(kind, blen);
  endtask

  // Drops valid and waits until every expected word has come out, then lets
  // the clock run on for a byte that is still inside the checker.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write enable stays high across back-to-back writes; the caller lowers it.
  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Register settings per phase. Unused upper data bits carry random junk,
  // which the checker must mask off.
  task automatic load_settings(input int unsigned ph);
    logic [31:0] hi;
    logic [63:0] lo;
    logic [15:0] lim;
    hi  = $urandom();
    lo  = {$urandom(), $urandom()};
    lim = MaxBodyLenReset;
    case (ph)
      1: begin
        hi  = '1;
        lo  = '1;
        lim = '0;
      end
      2: lim = 16'($urandom_range(300, 2000));
      3: lim = 16'($urandom_range(1, 40));
      4: hi = '0;
      default: lim = 16'hFFFF;
    endcase
    cfg_write(CFG_MAGIC_HIGH, {32'($urandom()), hi});
    cfg_write(CFG_MAGIC_LOW, lo);
    cfg_write(CFG_MAX_BODY_LEN, {16'($urandom()), 32'($urandom()), lim});
    if (ph == 1 || ph == PhaseCount - 1) cfg_write(CfgUnused, {$urandom(), $urandom()});
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned phase_end;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      if (ph > 0) load_settings(ph);
      // First the sender idles less than the receiver stalls, then the
      // other way round, and in the last phases neither side holds back.
      if (ph < 2) begin
        send_idle_pct  = 30;
        recv_stall_pct = 55;
      end else if (ph < 4) begin
        send_idle_pct  = 55;
        recv_stall_pct = 30;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      if (ph == 0) begin
        // With the reset registers the magic is all zeros: a stray byte, a
        // good frame with an empty body, and the largest possible length.
        send_byte(8'hFF);
        send_frame(FR_GOOD, 16'd0);
        send_frame(FR_TOO_LONG, 16'hFFFF);
      end
      phase_end = bytes_sent + ItemsPerPhase;
      while (bytes_sent < phase_end) send_random_frame();
      calm = 1'b0;
      drain();
    end
    if (sb.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/mlcfc_pkg.sv
hdl/magic_length_crc_frame_checker.sv
bench/frame_check_tb_pkg.sv
bench/magic_length_crc_frame_checker_tb.sv
